FILE: hdl/lphd_pkg.sv
`timescale 1ns / 1ps

package lphd_pkg;

	// Field widths fixed by the request and result formats
	localparam int ACT_W        = 2;
	localparam int KEY_W        = 31;
	localparam int VAL_W        = 64;
	localparam int STATUS_W     = 3;
	localparam int SLOT_FIELD_W = 5;

	// Action codes; the unused code behaves as a find
	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_FIND   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;
	localparam logic [STATUS_W-1:0] ST_KEY_ZERO  = 3'd6;

	// Handshake between the sequencer and the modulo unit
	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

endpackage

FILE: hdl/lphd_ram.sv
`timescale 1ns / 1ps

module lphd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry and register one read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: hdl/lphd_mod.sv
`timescale 1ns / 1ps

module lphd_mod #(
	parameter int SLOTS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [lphd_pkg::KEY_W-1:0] dividend,
	output logic                      done,
	output logic [$clog2(SLOTS)-1:0]  rem
);

	import lphd_pkg::*;

	localparam int SW = $clog2(SLOTS);
	localparam int PW = KEY_W + 32;
	// Rounded-up reciprocal of SLOTS scaled by 2^(KEY_W+SW); the quotient is exact
	// for every key because the rounding error stays below one part in SLOTS
	localparam logic [31:0] RECIP =
		32'(((64'd1 << (KEY_W + SW)) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));
	localparam logic [SW-1:0] DIVISOR_LO = SW'(SLOTS);

	logic             vld_s1;
	logic [KEY_W-1:0] key_s1;
	logic [PW-1:0]    prod_s1;
	logic             done_q;
	logic [SW-1:0]    rem_q;
	logic [SW-1:0]    quot_lo;
	logic [SW-1:0]    back_lo;

	// Take the low quotient bits and multiply back by the divisor, modulo 2^SW
	always_comb begin
		quot_lo = prod_s1[KEY_W+SW +: SW];
		back_lo = quot_lo * DIVISOR_LO;
	end

	// Advance the valid flag through the two stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			done_q <= vld_s1;
		end
	end

	// Multiply by the reciprocal, then subtract the quotient times the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			key_s1  <= dividend;
			prod_s1 <= PW'(dividend) * PW'(RECIP);
		end
		if (vld_s1) begin
			rem_q <= key_s1[SW-1:0] - back_lo;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

FILE: hdl/linear_probe_hash_dictionary_core.sv
`timescale 1ns / 1ps

// Key/value table of SLOTS entries with open addressing and linear probing from the
// home slot (key modulo SLOTS). One request is handled at a time and req_stall is
// high while it runs. After reset a clearing pass empties the key memory with
// req_stall high. A request with key zero answers with ST_KEY_ZERO and no scan.
// Find and delete read every key once through the single read port of the key
// memory. Insert first works out the home slot by multiplying with a reciprocal of
// SLOTS and then makes the same full pass, which finds duplicates and the first free
// slot in probe order together. A finished result waits in the output register
// while the next request can already be accepted, from the cycle after the result
// is loaded.
module linear_probe_hash_dictionary_core #(
	parameter int SLOTS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [lphd_pkg::ACT_W-1:0]        action,
	input  logic [lphd_pkg::KEY_W-1:0]        lookup_key,
	input  logic [lphd_pkg::VAL_W-1:0]        entry_value,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [lphd_pkg::STATUS_W-1:0]     status,
	output logic [lphd_pkg::SLOT_FIELD_W-1:0] slot_index,
	output logic [lphd_pkg::VAL_W-1:0]        found_value
);

	import lphd_pkg::*;

	localparam int SW = $clog2(SLOTS);
	localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

	localparam logic [2:0] S_CLEAR   = 3'd0;
	localparam logic [2:0] S_IDLE    = 3'd1;
	localparam logic [2:0] S_DIV     = 3'd2;
	localparam logic [2:0] S_SCAN    = 3'd3;
	localparam logic [2:0] S_RESOLVE = 3'd4;
	localparam logic [2:0] S_DONE    = 3'd5;

	logic [2:0]        state_q;
	logic [ACT_W-1:0]  act_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	logic [SW-1:0]     home_q;
	logic [SW-1:0]     addr_q;
	logic              issue_q;
	logic              rd_vld_q;
	logic [SW-1:0]     rd_idx_q;
	logic              hit_q;
	logic [SW-1:0]     hit_idx_q;
	logic [VAL_W-1:0]  hit_val_q;
	logic              emp_hi_q;
	logic [SW-1:0]     emp_hi_idx_q;
	logic              emp_any_q;
	logic [SW-1:0]     emp_any_idx_q;
	logic [STATUS_W-1:0] st_status_q;
	logic [SW-1:0]     st_slot_q;
	logic [VAL_W-1:0]  st_value_q;
	logic              res_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_FIELD_W-1:0] slot_index_q;
	logic [VAL_W-1:0]  found_value_q;

	logic              accept;
	logic              out_free;
	div_ctl_t          div_ctl;
	logic [SW-1:0]     div_rem;
	logic              key_wr_en;
	logic [SW-1:0]     key_wr_addr;
	logic [KEY_W-1:0]  key_wr_data;
	logic              val_wr_en;
	logic [SW-1:0]     val_wr_addr;
	logic              rd_en;
	logic [KEY_W-1:0]  key_rd;
	logic [VAL_W-1:0]  val_rd;

	// Take the low bits of a slot number for the result field
	function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SW-1:0] s);
		logic [31:0] w;
		w = 32'(s);
		return w[SLOT_FIELD_W-1:0];
	endfunction

	assign accept   = req_valid && (state_q == S_IDLE);
	assign out_free = !res_valid_q || !res_stall;
	assign rd_en    = (state_q == S_SCAN) && issue_q;
	assign div_ctl.start = accept && (lookup_key != '0) && (action == ACT_INSERT);

	lphd_mod #(
		.SLOTS(SLOTS)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_ctl.start),
		.dividend (lookup_key),
		.done     (div_ctl.done),
		.rem      (div_rem)
	);

	lphd_ram #(
		.WIDTH(KEY_W),
		.DEPTH(SLOTS)
	) u_keys (
		.clk     (clk),
		.wr_en   (key_wr_en),
		.wr_addr (key_wr_addr),
		.wr_data (key_wr_data),
		.rd_en   (rd_en),
		.rd_addr (addr_q),
		.rd_data (key_rd)
	);

	lphd_ram #(
		.WIDTH(VAL_W),
		.DEPTH(SLOTS)
	) u_values (
		.clk     (clk),
		.wr_en   (val_wr_en),
		.wr_addr (val_wr_addr),
		.wr_data (val_q),
		.rd_en   (rd_en),
		.rd_addr (addr_q),
		.rd_data (val_rd)
	);

	// Drive memory writes: clearing pass, insert, delete
	always_comb begin
		key_wr_en   = 1'b0;
		key_wr_addr = addr_q;
		key_wr_data = '0;
		val_wr_en   = 1'b0;
		val_wr_addr = emp_hi_q ? emp_hi_idx_q : emp_any_idx_q;
		if (state_q == S_CLEAR) begin
			key_wr_en = 1'b1;
		end else if (state_q == S_RESOLVE) begin
			if (act_q == ACT_INSERT) begin
				if (!hit_q && (emp_hi_q || emp_any_q)) begin
					key_wr_en   = 1'b1;
					key_wr_addr = val_wr_addr;
					key_wr_data = key_q;
					val_wr_en   = 1'b1;
				end
			end else if (act_q == ACT_DELETE) begin
				if (hit_q) begin
					key_wr_en   = 1'b1;
					key_wr_addr = hit_idx_q;
				end
			end
		end
	end

	// Sequence clear, modulo, scan and resolve
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			addr_q   <= '0;
			issue_q  <= 1'b0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= rd_en;
			unique case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == LAST_SLOT) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						addr_q  <= '0;
						issue_q <= 1'b1;
						if (lookup_key == '0) begin
							state_q <= S_DONE;
						end else if (action == ACT_INSERT) begin
							state_q <= S_DIV;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_DIV: begin
					if (div_ctl.done) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue_q) begin
						addr_q <= addr_q + 1'b1;
						if (addr_q == LAST_SLOT) begin
							issue_q <= 1'b0;
						end
					end
					if (rd_vld_q && (rd_idx_q == LAST_SLOT)) begin
						state_q <= S_RESOLVE;
					end
				end
				S_RESOLVE: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture the request and the home slot
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			key_q <= lookup_key;
			val_q <= entry_value;
		end
		if (div_ctl.done) begin
			home_q <= div_rem;
		end
		if (rd_en) begin
			rd_idx_q <= addr_q;
		end
	end

	// Track key match and first free slot at or after home, and overall
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q     <= 1'b0;
			emp_hi_q  <= 1'b0;
			emp_any_q <= 1'b0;
		end else if (rd_vld_q) begin
			if (key_rd == key_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= rd_idx_q;
				hit_val_q <= val_rd;
			end
			if (key_rd == '0) begin
				if (!emp_any_q) begin
					emp_any_q     <= 1'b1;
					emp_any_idx_q <= rd_idx_q;
				end
				if (!emp_hi_q && (rd_idx_q >= home_q)) begin
					emp_hi_q     <= 1'b1;
					emp_hi_idx_q <= rd_idx_q;
				end
			end
		end
	end

	// Form the result of the request
	always_ff @(posedge clk) begin
		if (accept) begin
			st_status_q <= ST_KEY_ZERO;
			st_slot_q   <= '0;
			st_value_q  <= '0;
		end else if (state_q == S_RESOLVE) begin
			case (act_q)
				ACT_INSERT: begin
					if (hit_q) begin
						st_status_q <= ST_DUPLICATE;
					end else if (emp_hi_q || emp_any_q) begin
						st_status_q <= ST_INSERTED;
						st_slot_q   <= val_wr_addr;
					end else begin
						st_status_q <= ST_FULL;
					end
				end
				ACT_DELETE: begin
					if (hit_q) begin
						st_status_q <= ST_DELETED;
						st_slot_q   <= hit_idx_q;
					end else begin
						st_status_q <= ST_NOT_FOUND;
					end
				end
				default: begin
					if (hit_q) begin
						st_status_q <= ST_FOUND;
						st_slot_q   <= hit_idx_q;
						st_value_q  <= hit_val_q;
					end else begin
						st_status_q <= ST_NOT_FOUND;
					end
				end
			endcase
		end
	end

	// Hold the result until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			status_q      <= st_status_q;
			slot_index_q  <= slot_field(st_slot_q);
			found_value_q <= st_value_q;
		end
	end

	assign req_stall   = (state_q != S_IDLE);
	assign res_valid   = res_valid_q;
	assign status      = status_q;
	assign slot_index  = slot_index_q;
	assign found_value = found_value_q;

endmodule
